@@ rtl/core/cmdv_pkg.sv @@
// shared types, constants and header decode for the command stream validator
`timescale 1ns / 1ps

package cmdv_pkg;

    // field widths
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 17;
    localparam int PLEFT_W  = 18;
    localparam int RING_W   = 25;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 2;

    // largest buffer accepted, in words
    localparam int unsigned MAX_BUFFER_WORDS = 65536;

    // ring size after reset, in bytes
    localparam logic [RING_W-1:0] RING_SIZE_RESET = RING_W'(131072);

    // fixed bytes the ring needs beyond the buffer: one extra word plus eight
    localparam logic [19:0] FIT_EXTRA_BYTES = 20'd12;

    // queue between decode and output, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERRUN = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TOOBIG  = 2'd3;

    // header client field
    localparam logic [2:0] CLIENT_MI = 3'h0;
    localparam logic [2:0] CLIENT_2D = 3'h2;
    localparam logic [2:0] CLIENT_3D = 3'h3;

    // misc-client opcodes that are allowed
    localparam logic [5:0] MI_NOOP       = 6'h00;
    localparam logic [5:0] MI_CACHE_SYNC = 6'h04;

    // 3d-client opcodes
    localparam logic [4:0] OP3D_SHORT_MAX = 5'h18;
    localparam logic [4:0] OP3D_SHORT_ALT = 5'h1c;
    localparam logic [4:0] OP3D_MULTI     = 5'h1d;
    localparam logic [4:0] OP3D_STATE     = 5'h1e;
    localparam logic [4:0] OP3D_PRIM      = 5'h1f;

    // sub-opcodes of the multi-dword 3d packet
    localparam logic [7:0] SUB_SHORT5 = 8'h03;
    localparam logic [7:0] SUB_SHORT4 = 8'h04;

    // one decoded word waiting for the output side
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic              last;      // final word of the buffer
        logic              pad;       // a zero pad result follows this one
    } t_entry;

    // packet length in words including the header; zero means illegal
    function automatic logic [PLEFT_W-1:0] packet_words(input logic [WORD_W-1:0] w);
        logic [2:0]         client;
        logic [5:0]         op6;
        logic [4:0]         op5;
        logic [7:0]         sub;
        logic [16:0]        half;
        logic [PLEFT_W-1:0] sz;
        client = w[31:29];
        op6    = w[28:23];
        op5    = w[28:24];
        sub    = w[23:16];
        half   = 17'((18'(w[15:0]) + 18'd1) >> 1);
        sz     = '0;
        case (client)
            CLIENT_MI: begin
                if (op6 == MI_NOOP || op6 == MI_CACHE_SYNC) begin
                    sz = PLEFT_W'(1);
                end
            end
            CLIENT_2D: begin
                sz = PLEFT_W'(w[7:0]) + PLEFT_W'(2);
            end
            CLIENT_3D: begin
                if (op5 <= OP3D_SHORT_MAX || op5 == OP3D_SHORT_ALT) begin
                    sz = PLEFT_W'(1);
                end else if (op5 == OP3D_MULTI) begin
                    if (sub == SUB_SHORT5) begin
                        sz = PLEFT_W'(w[4:0]) + PLEFT_W'(2);
                    end else if (sub == SUB_SHORT4) begin
                        sz = PLEFT_W'(w[3:0]) + PLEFT_W'(2);
                    end else begin
                        sz = PLEFT_W'(w[15:0]) + PLEFT_W'(2);
                    end
                end else if (op5 == OP3D_STATE) begin
                    sz = w[23] ? PLEFT_W'(w[15:0]) + PLEFT_W'(1) : PLEFT_W'(1);
                end else if (op5 == OP3D_PRIM) begin
                    if (!w[23]) begin
                        sz = PLEFT_W'(w[16:0]) + PLEFT_W'(2);
                    end else if (w[17]) begin
                        sz = (w[15:0] == 16'd0) ? '0 : PLEFT_W'(half) + PLEFT_W'(1);
                    end else begin
                        sz = PLEFT_W'(2);
                    end
                end else begin
                    sz = '0;
                end
            end
            default: begin
                sz = '0;
            end
        endcase
        return sz;
    endfunction

endpackage

@@ rtl/core/cmdv_front.sv @@
// decode side: buffer tracking, fit check, header decode and rejection
`timescale 1ns / 1ps

module cmdv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cmdv_pkg::RING_W-1:0]   i_cfg_wr_data,
    input  logic                          i_accept,
    input  logic [cmdv_pkg::WORD_W-1:0]   i_word,
    input  logic [cmdv_pkg::LEN_W-1:0]    i_buffer_length,
    input  logic                          i_first_of_buffer,
    output logic                          o_wr_en,
    output cmdv_pkg::t_entry              o_wr_data
);
    import cmdv_pkg::*;

    logic [RING_W-1:0]  r_ring_size;
    logic [PLEFT_W-1:0] r_payload_left, n_payload_left;
    logic [LEN_W-1:0]   r_word_index, n_word_index;
    logic [LEN_W-1:0]   r_length, n_length;
    logic               r_rejected, n_rejected;

    logic [LEN_W-1:0]   eff_len, eff_idx, idx_inc;
    logic [PLEFT_W-1:0] eff_pleft, sz;
    logic               eff_rej, too_big, past_end, overrun, do_reject;
    logic [19:0]        need_bytes;
    logic [LEN_W+1:0]   pkt_end;
    logic [ERR_W-1:0]   rej_code;
    logic [KIND_W-1:0]  kind;

    // a first word restarts all counters
    assign eff_len   = i_first_of_buffer ? i_buffer_length : r_length;
    assign eff_idx   = i_first_of_buffer ? '0 : r_word_index;
    assign eff_pleft = i_first_of_buffer ? '0 : r_payload_left;
    assign eff_rej   = i_first_of_buffer ? 1'b0 : r_rejected;

    assign need_bytes = 20'({i_buffer_length, 2'b00}) + FIT_EXTRA_BYTES;
    assign too_big    = i_first_of_buffer && (i_buffer_length != '0) &&
                        ((RING_W'(need_bytes) >= r_ring_size) ||
                         (32'(i_buffer_length) > MAX_BUFFER_WORDS));

    assign past_end = eff_rej || (eff_idx >= eff_len);
    assign sz       = packet_words(i_word);
    assign pkt_end  = (LEN_W+2)'(eff_idx) + (LEN_W+2)'(sz);
    assign overrun  = pkt_end > (LEN_W+2)'(eff_len);
    assign idx_inc  = eff_idx + LEN_W'(1);

    always_comb begin
        n_length       = eff_len;
        n_word_index   = eff_idx;
        n_payload_left = eff_pleft;
        n_rejected     = eff_rej;
        do_reject      = 1'b0;
        rej_code       = ERR_NONE;
        kind           = KIND_HEADER;
        o_wr_en        = 1'b0;
        if (too_big) begin
            do_reject = 1'b1;
            rej_code  = ERR_TOOBIG;
        end else if (!past_end) begin
            if (eff_pleft != '0) begin
                n_payload_left = eff_pleft - PLEFT_W'(1);
                kind           = KIND_PAYLOAD;
                n_word_index   = idx_inc;
                o_wr_en        = 1'b1;
            end else if (sz == '0) begin
                do_reject = 1'b1;
                rej_code  = ERR_ILLEGAL;
            end else if (overrun) begin
                do_reject = 1'b1;
                rej_code  = ERR_OVERRUN;
            end else begin
                n_payload_left = sz - PLEFT_W'(1);
                kind           = KIND_HEADER;
                n_word_index   = idx_inc;
                o_wr_en        = 1'b1;
            end
        end
        if (do_reject) begin
            n_rejected     = 1'b1;
            n_payload_left = '0;
            o_wr_en        = 1'b1;
        end
        o_wr_en = o_wr_en && i_accept;
    end

    always_comb begin
        o_wr_data.word = do_reject ? '0 : i_word;
        o_wr_data.kind = do_reject ? KIND_REJECT : kind;
        o_wr_data.err  = rej_code;
        o_wr_data.last = do_reject || (idx_inc == eff_len);
        o_wr_data.pad  = !do_reject && (idx_inc == eff_len) && eff_len[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size    <= RING_SIZE_RESET;
            r_payload_left <= '0;
            r_word_index   <= '0;
            r_length       <= '0;
            r_rejected     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ring_size <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_payload_left <= n_payload_left;
                r_word_index   <= n_word_index;
                r_length       <= n_length;
                r_rejected     <= n_rejected;
            end
        end
    end

endmodule

@@ rtl/core/cmdv_queue.sv @@
// small register queue between the decode side and the output side
`timescale 1ns / 1ps

module cmdv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  cmdv_pkg::t_entry i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output cmdv_pkg::t_entry o_rd_data,
    output logic             o_empty
);
    import cmdv_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                wr_fire, rd_fire;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/cmdv_back.sv @@
// output side: result register and zero pad insertion
`timescale 1ns / 1ps

module cmdv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  cmdv_pkg::t_entry              i_q_data,
    output logic                          o_q_rd_en,
    output logic                          empty,
    input  logic                          pop,
    output logic [cmdv_pkg::WORD_W-1:0]   o_out_word,
    output logic [cmdv_pkg::KIND_W-1:0]   o_kind,
    output logic [cmdv_pkg::ERR_W-1:0]    o_error_code,
    output logic                          o_last_of_buffer
);
    import cmdv_pkg::*;

    logic               r_valid;
    logic               r_pad_pending;
    logic [WORD_W-1:0]  r_word;
    logic [KIND_W-1:0]  r_kind;
    logic [ERR_W-1:0]   r_err;
    logic               r_last;
    logic               load;

    assign load      = !r_valid || pop;
    assign o_q_rd_en = load && !r_pad_pending && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_pad_pending <= 1'b0;
        end else if (load) begin
            if (r_pad_pending) begin
                r_valid       <= 1'b1;
                r_pad_pending <= 1'b0;
            end else begin
                r_valid       <= !i_q_empty;
                r_pad_pending <= !i_q_empty && i_q_data.pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pad_pending) begin
                r_word <= '0;
                r_kind <= KIND_PAD;
                r_err  <= ERR_NONE;
                r_last <= 1'b1;
            end else begin
                r_word <= i_q_data.word;
                r_kind <= i_q_data.kind;
                r_err  <= i_q_data.err;
                r_last <= i_q_data.last && !i_q_data.pad;
            end
        end
    end

    assign empty            = !r_valid;
    assign o_out_word       = r_word;
    assign o_kind           = r_kind;
    assign o_error_code     = r_err;
    assign o_last_of_buffer = r_last;

`ifndef ASSERT_OFF
    // a pending pad always sits behind a shown result
    a_pad_behind_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_pending |-> r_valid)
        else $error("pad pending with no result shown");

    // the pad is the very next result after the word that asked for it
    a_pad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_pad_pending) |=> (r_valid && r_kind == KIND_PAD))
        else $error("pad result not emitted next");

    // error code is set exactly on rejections
    a_err_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_kind == KIND_REJECT) == (r_err != ERR_NONE)))
        else $error("error code and kind disagree");

    // a pad or a rejection always closes the buffer
    a_close_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_PAD || r_kind == KIND_REJECT)) |-> r_last)
        else $error("pad or rejection without last mark");
`endif

endmodule

@@ rtl/core/gpu_command_stream_validator_unit.sv @@
// top level of the command stream validator
`timescale 1ns / 1ps

// Checks a command buffer one 32-bit word per transfer and passes legal words on
// toward the command ring. The first word of a buffer (first_of_buffer high)
// latches the buffer length and checks that the buffer fits the ring configured
// through i_cfg_wr_en / i_cfg_wr_data (ring size in bytes, 131072 after reset).
// Header words are decoded by client and opcode into a packet length; payload
// words follow unchanged. An illegal header, a packet running past the buffer
// end, or a buffer too large for the ring yields one result of kind rejected with
// the error code and last_of_buffer set; the rest of that buffer is swallowed and
// the consumer must drop what it already took for the buffer. A buffer with an
// odd word count ends with an extra zero pad result carrying the last mark.
// Words beyond the latched length, or before any buffer, give no result.
// Input and output look like queues: an input transfer happens when push is high
// and full is low, an output transfer when pop is high and empty is low. The
// block takes one word per clock while full is low. The decode side updates its
// counters with each transfer and writes a four-entry queue; a word passes that
// queue and then the output register, which drains it at one result per clock
// while pop is high, so an odd-length buffer needs one extra result for its pad.
// Configuration is to be written only while the block is idle.
module gpu_command_stream_validator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [cmdv_pkg::RING_W-1:0]   i_cfg_wr_data,
    // command words in
    input  logic                          push,
    output logic                          full,
    input  logic [cmdv_pkg::WORD_W-1:0]   i_word,
    input  logic [cmdv_pkg::LEN_W-1:0]    i_buffer_length,
    input  logic                          i_first_of_buffer,
    // results out
    output logic                          empty,
    input  logic                          pop,
    output logic [cmdv_pkg::WORD_W-1:0]   o_out_word,
    output logic [cmdv_pkg::KIND_W-1:0]   o_kind,
    output logic [cmdv_pkg::ERR_W-1:0]    o_error_code,
    output logic                          o_last_of_buffer
);
    import cmdv_pkg::*;

    logic   accept;
    logic   q_wr_en;
    t_entry q_wr_data;
    logic   q_full;
    logic   q_rd_en;
    t_entry q_rd_data;
    logic   q_empty;

    // input transfer when the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    // decode side
    cmdv_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_accept          (accept),
        .i_word            (i_word),
        .i_buffer_length   (i_buffer_length),
        .i_first_of_buffer (i_first_of_buffer),
        .o_wr_en           (q_wr_en),
        .o_wr_data         (q_wr_data)
    );

    // decouples decode from output stalls
    cmdv_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // output register with pad insertion
    cmdv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rd_data),
        .o_q_rd_en        (q_rd_en),
        .empty            (empty),
        .pop              (pop),
        .o_out_word       (o_out_word),
        .o_kind           (o_kind),
        .o_error_code     (o_error_code),
        .o_last_of_buffer (o_last_of_buffer)
    );

endmodule
